[design/dppt_pkg.sv]
// ----------------------------------------------------------------------------
// dppt_pkg
// Shared types and constants for the dual pedal plausibility and torque block.
// ----------------------------------------------------------------------------
package dppt_pkg;

  localparam int ADC_BITS     = 10;
  localparam int PEDAL_SCALE  = 255;
  localparam int PEDAL_SKEW   = 10;
  localparam int TRAVEL_MARGIN = 4 * PEDAL_SKEW;
  localparam int DEADBAND     = 10;
  localparam int NUM_W        = ADC_BITS + 8;   // (raw - low) * 255
  localparam int QUOT_BITS    = 8;
  localparam int X_W          = 24;             // (avg - deadband) * 10 * limit
  // floor(2^31 / 245): reciprocal of the torque span, corrected afterwards
  localparam int RECIP_SHIFT  = 31;
  localparam logic [23:0] RECIP_245 = 24'd8765239;
  localparam int TORQUE_SPAN  = PEDAL_SCALE - DEADBAND;

  typedef enum logic [2:0] {
    REG_PEDAL_A_LOW, REG_PEDAL_A_HIGH, REG_PEDAL_B_LOW, REG_PEDAL_B_HIGH,
    REG_TORQUE_LIMIT, REG_COAST_REGEN, REG_BRAKE_REGEN_GAIN, REG_BRAKE_FULL_SCALE
  } reg_idx_t;

  typedef struct packed {
    logic [ADC_BITS-1:0] pedal_a_low;
    logic [ADC_BITS-1:0] pedal_a_high;
    logic [ADC_BITS-1:0] pedal_b_low;
    logic [ADC_BITS-1:0] pedal_b_high;
    logic [11:0]         torque_limit;
    logic [11:0]         coast_regen;
    logic [15:0]         brake_regen_gain;
    logic [15:0]         brake_full_scale;
  } cfg_t;

  // classified item handed from front to back
  typedef struct packed {
    logic                ok_a;
    logic                ok_b;
    logic [NUM_W-1:0]    num_a;
    logic [ADC_BITS-1:0] den_a;
    logic [NUM_W-1:0]    num_b;
    logic [ADC_BITS-1:0] den_b;
    logic [15:0]         brake_a;
    logic [15:0]         brake_b;
    logic [31:0]         regen_prod;
    logic [15:0]         coast10;
    logic                ready;
  } item_t;

  // fields riding alongside the dividers
  typedef struct packed {
    logic        ok_a;
    logic        ok_b;
    logic [15:0] brake_a;
    logic [15:0] brake_b;
    logic [31:0] regen_prod;
    logic [15:0] coast10;
    logic        ready;
  } carry_t;

endpackage

[design/dppt_front.sv]
// ----------------------------------------------------------------------------
// dppt_front
// Accepts a sample set, checks pedal travel and forms divider operands,
// brake pressures and the regen product.
// ----------------------------------------------------------------------------
module dppt_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         take,
  input  logic [dppt_pkg::ADC_BITS-1:0] pedal_a_raw,
  input  logic [dppt_pkg::ADC_BITS-1:0] pedal_b_raw,
  input  logic [dppt_pkg::ADC_BITS-1:0] brake_a_raw,
  input  logic [dppt_pkg::ADC_BITS-1:0] brake_b_raw,
  input  logic [15:0]                  front_pressure,
  input  logic                         ready_req,
  input  dppt_pkg::cfg_t               cfg,
  output logic                         item_valid,
  output dppt_pkg::item_t              item
);

  localparam int AB = dppt_pkg::ADC_BITS;
  localparam int BP_W = AB + 16;

  logic [AB:0]    lim_a, lim_b;
  logic           ok_a, ok_b;
  logic [AB-1:0]  d_a, d_b;
  logic [BP_W-1:0] bp_a, bp_b;
  logic [BP_W-1:0] bs_a, bs_b;
  dppt_pkg::item_t item_next;

  always_comb begin
    lim_a = {1'b0, cfg.pedal_a_high} + (AB+1)'(dppt_pkg::TRAVEL_MARGIN);
    lim_b = {1'b0, cfg.pedal_b_high} + (AB+1)'(dppt_pkg::TRAVEL_MARGIN);
    ok_a = (cfg.pedal_a_high > cfg.pedal_a_low) && (pedal_a_raw >= cfg.pedal_a_low)
           && ({1'b0, pedal_a_raw} <= lim_a);
    ok_b = (cfg.pedal_b_high > cfg.pedal_b_low) && (pedal_b_raw >= cfg.pedal_b_low)
           && ({1'b0, pedal_b_raw} <= lim_b);
    d_a = pedal_a_raw - cfg.pedal_a_low;
    d_b = pedal_b_raw - cfg.pedal_b_low;
    bp_a = BP_W'(brake_a_raw) * BP_W'(cfg.brake_full_scale);
    bp_b = BP_W'(brake_b_raw) * BP_W'(cfg.brake_full_scale);
    bs_a = bp_a >> AB;
    bs_b = bp_b >> AB;

    item_next.ok_a  = ok_a;
    item_next.ok_b  = ok_b;
    // x*255 as (x<<8) - x
    item_next.num_a = (dppt_pkg::NUM_W'(d_a) << 8) - dppt_pkg::NUM_W'(d_a);
    item_next.num_b = (dppt_pkg::NUM_W'(d_b) << 8) - dppt_pkg::NUM_W'(d_b);
    item_next.den_a = cfg.pedal_a_high - cfg.pedal_a_low;
    item_next.den_b = cfg.pedal_b_high - cfg.pedal_b_low;
    item_next.brake_a = (bs_a > BP_W'(16'hFFFF)) ? 16'hFFFF : bs_a[15:0];
    item_next.brake_b = (bs_b > BP_W'(16'hFFFF)) ? 16'hFFFF : bs_b[15:0];
    item_next.regen_prod = 32'(cfg.brake_regen_gain) * 32'(front_pressure);
    item_next.coast10 = (16'(cfg.coast_regen) << 3) + (16'(cfg.coast_regen) << 1);
    item_next.ready = ready_req;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      item_valid <= take;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item <= item_next;
    end
  end

endmodule

[design/dppt_queue.sv]
// ----------------------------------------------------------------------------
// dppt_queue
// Two-entry queue between front and back.
// ----------------------------------------------------------------------------
module dppt_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  dppt_pkg::item_t push_item,
  input  logic            pop,
  output logic            head_valid,
  output dppt_pkg::item_t head_item,
  output logic            full
);

  dppt_pkg::item_t entry [2];
  logic       wptr, rptr;
  logic [1:0] count;

  assign head_valid = (count != 2'd0);
  assign head_item  = entry[rptr];
  assign full       = (count == 2'd2);

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop && head_valid) rptr <= ~rptr;
      count <= count + 2'(push) - 2'(pop && head_valid);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wptr] <= push_item;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && full && !pop)) else $error("queue overflow");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count != 2'd3) else $error("queue count out of range");
  a_ptr_gap: assert property (@(posedge clk) disable iff (rst)
    (count == 2'd1) |-> (wptr != rptr)) else $error("queue pointers inconsistent");

endmodule

[design/dppt_back.sv]
// ----------------------------------------------------------------------------
// dppt_back
// Pedal dividers, plausibility, torque mapping and the result register.
// ----------------------------------------------------------------------------
module dppt_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  dppt_pkg::item_t in_item,
  input  dppt_pkg::cfg_t  cfg,
  output logic            done,
  output logic [7:0]      pedal_a_pos,
  output logic [7:0]      pedal_b_pos,
  output logic            pedal_fault,
  output logic [15:0]     brake_a_pressure,
  output logic [15:0]     brake_b_pressure,
  output logic signed [15:0] torque_cmd,
  output logic            drive_enable
);

  localparam int NW = dppt_pkg::NUM_W;
  localparam int AB = dppt_pkg::ADC_BITS;
  localparam int QB = dppt_pkg::QUOT_BITS;
  localparam int XW = dppt_pkg::X_W;

  // divider line: index 0 is the queue head, index QB the last stage
  logic               dv_valid [QB+1];
  logic [NW-1:0]      rem_a [QB+1];
  logic [NW-1:0]      rem_b [QB+1];
  logic [AB-1:0]      den_a [QB+1];
  logic [AB-1:0]      den_b [QB+1];
  logic [QB-1:0]      quo_a [QB+1];
  logic [QB-1:0]      quo_b [QB+1];
  logic               sat_a [QB+1];
  logic               sat_b [QB+1];
  dppt_pkg::carry_t   cry   [QB+1];

  always_comb begin
    dv_valid[0] = in_valid;
    rem_a[0] = in_item.num_a;
    rem_b[0] = in_item.num_b;
    den_a[0] = in_item.den_a;
    den_b[0] = in_item.den_b;
    quo_a[0] = '0;
    quo_b[0] = '0;
    // quotient of 256 or more saturates
    sat_a[0] = in_item.num_a >= {in_item.den_a, 8'b0};
    sat_b[0] = in_item.num_b >= {in_item.den_b, 8'b0};
    cry[0].ok_a = in_item.ok_a;
    cry[0].ok_b = in_item.ok_b;
    cry[0].brake_a = in_item.brake_a;
    cry[0].brake_b = in_item.brake_b;
    cry[0].regen_prod = in_item.regen_prod;
    cry[0].coast10 = in_item.coast10;
    cry[0].ready = in_item.ready;
  end

  for (genvar s = 0; s < QB; s++) begin : g_div
    localparam int B = QB - 1 - s;
    logic [NW-1:0] trial_a, trial_b;
    assign trial_a = NW'(den_a[s]) << B;
    assign trial_b = NW'(den_b[s]) << B;

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_valid[s+1] <= 1'b0;
      end else begin
        dv_valid[s+1] <= dv_valid[s];
      end
    end

    always_ff @(posedge clk) begin
      den_a[s+1] <= den_a[s];
      den_b[s+1] <= den_b[s];
      sat_a[s+1] <= sat_a[s];
      sat_b[s+1] <= sat_b[s];
      cry[s+1]   <= cry[s];
      if (rem_a[s] >= trial_a) begin
        rem_a[s+1] <= rem_a[s] - trial_a;
        quo_a[s+1] <= quo_a[s] | QB'(1 << B);
      end else begin
        rem_a[s+1] <= rem_a[s];
        quo_a[s+1] <= quo_a[s];
      end
      if (rem_b[s] >= trial_b) begin
        rem_b[s+1] <= rem_b[s] - trial_b;
        quo_b[s+1] <= quo_b[s] | QB'(1 << B);
      end else begin
        rem_b[s+1] <= rem_b[s];
        quo_b[s+1] <= quo_b[s];
      end
    end
  end

  // plausibility stage
  logic [7:0]  pa_c, pb_c, avg_c;
  logic        fault_c;
  logic [32:0] regen_sum;
  logic [19:0] span_prod;

  logic        m_valid, m_fault, m_below, m_ready;
  logic [7:0]  m_pa, m_pb;
  logic [XW-1:0] m_x;
  logic [15:0] m_regen, m_brake_a, m_brake_b;

  always_comb begin
    pa_c = sat_a[QB] ? 8'd255 : quo_a[QB];
    pb_c = sat_b[QB] ? 8'd255 : quo_b[QB];
    fault_c = !(cry[QB].ok_a && cry[QB].ok_b);
    if (fault_c) begin
      pa_c = '0;
      pb_c = '0;
    end
    if ((9'(pa_c) > 9'(pb_c) + 9'(dppt_pkg::PEDAL_SKEW)) ||
        (9'(pb_c) > 9'(pa_c) + 9'(dppt_pkg::PEDAL_SKEW))) begin
      pa_c = '0;
      pb_c = '0;
      fault_c = 1'b1;
    end
    avg_c = 8'(pa_c >> 1) + 8'(pb_c >> 1);
    span_prod = 20'(avg_c - 8'(dppt_pkg::DEADBAND)) * 20'(cfg.torque_limit);
    regen_sum = 33'(cry[QB].regen_prod) + 33'(cry[QB].coast10);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else begin
      m_valid <= dv_valid[QB];
    end
  end

  always_ff @(posedge clk) begin
    m_pa <= pa_c;
    m_pb <= pb_c;
    m_fault <= fault_c;
    m_below <= avg_c < 8'(dppt_pkg::DEADBAND);
    m_x <= (XW'(span_prod) << 3) + (XW'(span_prod) << 1);
    m_regen <= (regen_sum >= 33'd32768) ? 16'h8000 : 16'(~regen_sum + 33'd1);
    m_ready <= cry[QB].ready;
    m_brake_a <= cry[QB].brake_a;
    m_brake_b <= cry[QB].brake_b;
  end

  // reciprocal multiply stage
  logic        r_valid, r_fault, r_below, r_ready;
  logic [7:0]  r_pa, r_pb;
  logic [XW-1:0] r_x;
  logic [47:0] r_prod;
  logic [15:0] r_regen, r_brake_a, r_brake_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      r_valid <= 1'b0;
    end else begin
      r_valid <= m_valid;
    end
  end

  always_ff @(posedge clk) begin
    r_prod <= 48'(m_x) * 48'(dppt_pkg::RECIP_245);
    r_x <= m_x;
    r_pa <= m_pa;
    r_pb <= m_pb;
    r_fault <= m_fault;
    r_below <= m_below;
    r_ready <= m_ready;
    r_regen <= m_regen;
    r_brake_a <= m_brake_a;
    r_brake_b <= m_brake_b;
  end

  // correction of the estimate (low by at most one) and result register
  logic [16:0] q_est, q_fix;
  logic [24:0] q_rem;
  logic signed [15:0] torque_next;

  always_comb begin
    q_est = r_prod[dppt_pkg::RECIP_SHIFT +: 17];
    q_rem = 25'(r_x) - 25'(q_est) * 25'(dppt_pkg::TORQUE_SPAN);
    q_fix = (q_rem >= 25'(dppt_pkg::TORQUE_SPAN)) ? q_est + 17'd1 : q_est;
    if (!r_ready) begin
      torque_next = '0;
    end else if (r_below) begin
      torque_next = r_regen;
    end else if (q_fix > 17'd32767) begin
      torque_next = 16'sd32767;
    end else begin
      torque_next = 16'(q_fix);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= r_valid;
    end
  end

  always_ff @(posedge clk) begin
    pedal_a_pos <= r_pa;
    pedal_b_pos <= r_pb;
    pedal_fault <= r_fault;
    brake_a_pressure <= r_brake_a;
    brake_b_pressure <= r_brake_b;
    torque_cmd <= torque_next;
    drive_enable <= r_ready;
  end

  a_fault_zero: assert property (@(posedge clk) disable iff (rst)
    (done && pedal_fault) |-> (pedal_a_pos == 8'd0 && pedal_b_pos == 8'd0))
    else $error("fault result carries pedal position");
  a_not_ready: assert property (@(posedge clk) disable iff (rst)
    (done && !drive_enable) |-> (torque_cmd == 16'sd0))
    else $error("torque without ready");
  a_skew: assert property (@(posedge clk) disable iff (rst)
    (done && !pedal_fault) |-> (9'(pedal_a_pos) <= 9'(pedal_b_pos) + 9'd10 &&
                               9'(pedal_b_pos) <= 9'(pedal_a_pos) + 9'd10))
    else $error("pedal mismatch passed");

endmodule

[design/dual_pedal_plausibility_torque_top.sv]
// ----------------------------------------------------------------------------
// dual_pedal_plausibility_torque_top
// Pedal plausibility check, brake scaling and torque command.
// ----------------------------------------------------------------------------
// One sample set may be started every cycle; busy stays low in normal use.
// Each set gives exactly one result, shown for one cycle with done high, after
// one front stage, the queue register, eight stages of the bit-per-stage
// pedal dividers, then plausibility, the reciprocal multiply for torque
// scaling and the result register. The receiver cannot stall, so results
// must be taken as they appear. Registers are written through wr_en,
// wr_index, wr_data; the user must do so with no item in flight (unchecked).
module dual_pedal_plausibility_torque_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [9:0]  pedal_a_raw,
  input  logic [9:0]  pedal_b_raw,
  input  logic [9:0]  brake_a_raw,
  input  logic [9:0]  brake_b_raw,
  input  logic [15:0] front_pressure,
  input  logic        ready_req,
  input  logic        wr_en,
  input  logic [2:0]  wr_index,
  input  logic [15:0] wr_data,
  output logic        done,
  output logic [7:0]  pedal_a_pos,
  output logic [7:0]  pedal_b_pos,
  output logic        pedal_fault,
  output logic [15:0] brake_a_pressure,
  output logic [15:0] brake_b_pressure,
  output logic signed [15:0] torque_cmd,
  output logic        drive_enable
);

  localparam int AB = dppt_pkg::ADC_BITS;

  dppt_pkg::cfg_t  cfg;
  logic            take, f_valid, q_valid, q_full;
  dppt_pkg::item_t f_item, q_item;

  assign busy = q_full;
  assign take = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pedal_a_low      <= AB'(189);
      cfg.pedal_a_high     <= AB'(849);
      cfg.pedal_b_low      <= AB'(91);
      cfg.pedal_b_high     <= AB'(417);
      cfg.torque_limit     <= 12'd50;
      cfg.coast_regen      <= 12'd10;
      cfg.brake_regen_gain <= 16'd0;
      cfg.brake_full_scale <= 16'd3000;
    end else if (wr_en) begin
      unique case (dppt_pkg::reg_idx_t'(wr_index))
        dppt_pkg::REG_PEDAL_A_LOW:      cfg.pedal_a_low      <= wr_data[AB-1:0];
        dppt_pkg::REG_PEDAL_A_HIGH:     cfg.pedal_a_high     <= wr_data[AB-1:0];
        dppt_pkg::REG_PEDAL_B_LOW:      cfg.pedal_b_low      <= wr_data[AB-1:0];
        dppt_pkg::REG_PEDAL_B_HIGH:     cfg.pedal_b_high     <= wr_data[AB-1:0];
        dppt_pkg::REG_TORQUE_LIMIT:     cfg.torque_limit     <= wr_data[11:0];
        dppt_pkg::REG_COAST_REGEN:      cfg.coast_regen      <= wr_data[11:0];
        dppt_pkg::REG_BRAKE_REGEN_GAIN: cfg.brake_regen_gain <= wr_data;
        dppt_pkg::REG_BRAKE_FULL_SCALE: cfg.brake_full_scale <= wr_data;
        default: ;
      endcase
    end
  end

  dppt_front u_front (
    .clk, .rst, .take,
    .pedal_a_raw, .pedal_b_raw, .brake_a_raw, .brake_b_raw,
    .front_pressure, .ready_req, .cfg,
    .item_valid(f_valid), .item(f_item)
  );

  dppt_queue u_queue (
    .clk, .rst,
    .push(f_valid), .push_item(f_item),
    .pop(1'b1), .head_valid(q_valid), .head_item(q_item), .full(q_full)
  );

  dppt_back u_back (
    .clk, .rst, .in_valid(q_valid), .in_item(q_item), .cfg,
    .done, .pedal_a_pos, .pedal_b_pos, .pedal_fault,
    .brake_a_pressure, .brake_b_pressure, .torque_cmd, .drive_enable
  );

endmodule

[tb/sv/tb_dual_pedal_plausibility_torque_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_dual_pedal_plausibility_torque_top
// Self-checking bench: directed and random sample sets against a local
// predictor of pedal scaling, plausibility, brake scaling and torque command.
// ----------------------------------------------------------------------------
module tb_dual_pedal_plausibility_torque_top;

  typedef struct {
    logic [9:0]  pa;
    logic [9:0]  pb;
    logic [9:0]  ba;
    logic [9:0]  bb;
    logic [15:0] fp;
    logic        rdy;
    bit          hold;   // wait for the pipe to drain before this item
  } sample_t;

  typedef struct {
    logic [7:0]         pa_pos;
    logic [7:0]         pb_pos;
    logic               fault;
    logic [15:0]        ba_p;
    logic [15:0]        bb_p;
    logic signed [15:0] torque;
    logic               en;
  } outcome_t;

  logic clk = 1'b0, rst = 1'b1;
  logic start = 1'b0, busy, done;
  logic [9:0] pedal_a_raw = '0, pedal_b_raw = '0, brake_a_raw = '0, brake_b_raw = '0;
  logic [15:0] front_pressure = '0;
  logic ready_req = 1'b0;
  logic wr_en = 1'b0;
  logic [2:0] wr_index = '0;
  logic [15:0] wr_data = '0;
  logic [7:0] pedal_a_pos, pedal_b_pos;
  logic pedal_fault, drive_enable;
  logic [15:0] brake_a_pressure, brake_b_pressure;
  logic signed [15:0] torque_cmd;

  dual_pedal_plausibility_torque_top dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  dppt_pkg::cfg_t cal;
  sample_t   pending_q[$];
  outcome_t  expected_q[$];
  int        mismatches = 0, n_results = 0, n_items = 0, n_faults = 0, n_regen = 0;
  int        idle_cycles = 0;
  bit        sender_calm = 0;
  int        gap = 0;

  function automatic bit scale_pedal(input int raw, input int lo, input int hi,
                                     output int pos);
    int v;
    pos = 0;
    if (hi <= lo || raw < lo || raw > hi + dppt_pkg::TRAVEL_MARGIN) return 0;
    v = (raw - lo) * dppt_pkg::PEDAL_SCALE / (hi - lo);
    pos = (v > dppt_pkg::PEDAL_SCALE) ? dppt_pkg::PEDAL_SCALE : v;
    return 1;
  endfunction

  function automatic logic [15:0] brake_pressure(input int raw);
    longint v;
    v = (longint'(raw) * cal.brake_full_scale) >>> dppt_pkg::ADC_BITS;
    return (v > 65535) ? 16'hFFFF : v[15:0];
  endfunction

  function automatic outcome_t predict_torque_result(input sample_t s);
    outcome_t o;
    int pa, pb, avg;
    bit ok_a, ok_b, fault;
    longint t;
    ok_a = scale_pedal(s.pa, cal.pedal_a_low, cal.pedal_a_high, pa);
    ok_b = scale_pedal(s.pb, cal.pedal_b_low, cal.pedal_b_high, pb);
    fault = !(ok_a && ok_b);
    if (fault) begin
      pa = 0;
      pb = 0;
    end
    if (pa > pb + dppt_pkg::PEDAL_SKEW || pb > pa + dppt_pkg::PEDAL_SKEW) begin
      pa = 0;
      pb = 0;
      fault = 1;
    end
    avg = pa / 2 + pb / 2;
    if (avg < dppt_pkg::DEADBAND)
      t = -10 * longint'(cal.coast_regen) - longint'(cal.brake_regen_gain) * s.fp;
    else
      t = longint'(avg - dppt_pkg::DEADBAND) * 10 * cal.torque_limit
          / dppt_pkg::TORQUE_SPAN;
    if (t > 32767) t = 32767;
    if (t < -32768) t = -32768;
    if (!s.rdy) t = 0;
    o.pa_pos = pa[7:0];
    o.pb_pos = pb[7:0];
    o.fault  = fault;
    o.ba_p   = brake_pressure(s.ba);
    o.bb_p   = brake_pressure(s.bb);
    o.torque = t[15:0];
    o.en     = s.rdy;
    return o;
  endfunction

  // driver: one item per accepted start, random gaps, optional drain hold
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        expected_q.push_back(predict_torque_result(pending_q.pop_front()));
        n_items++;
      end
      if (start && busy) begin
        // keep holding the current item
      end else if (gap > 0) begin
        gap--;
        start <= 1'b0;
      end else if (pending_q.size() > 0 &&
                   !(pending_q[0].hold && (expected_q.size() > 0 || start))) begin
        if (!sender_calm && $urandom_range(0, 5) == 0) begin
          gap = $urandom_range(1, 10);
          start <= 1'b0;
        end else begin
          start          <= 1'b1;
          pedal_a_raw    <= pending_q[0].pa;
          pedal_b_raw    <= pending_q[0].pb;
          brake_a_raw    <= pending_q[0].ba;
          brake_b_raw    <= pending_q[0].bb;
          front_pressure <= pending_q[0].fp;
          ready_req      <= pending_q[0].rdy;
          pending_q[0].hold = 0;
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst && done) begin
      outcome_t e;
      n_results++;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result at %0t", $time);
      end else begin
        e = expected_q.pop_front();
        if (e.fault) n_faults++;
        if (e.torque < 0) n_regen++;
        if (pedal_a_pos !== e.pa_pos || pedal_b_pos !== e.pb_pos ||
            pedal_fault !== e.fault || brake_a_pressure !== e.ba_p ||
            brake_b_pressure !== e.bb_p || torque_cmd !== e.torque ||
            drive_enable !== e.en) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch at %0t: exp %h %h %b %h %h %0d %b got %h %h %b %h %h %0d %b",
                     $time, e.pa_pos, e.pb_pos, e.fault, e.ba_p, e.bb_p, e.torque, e.en,
                     pedal_a_pos, pedal_b_pos, pedal_fault, brake_a_pressure,
                     brake_b_pressure, torque_cmd, drive_enable);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((start && !busy) || done || rst || (pending_q.size() == 0 && expected_q.size() == 0))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 2000) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic add_item(input int pa, input int pb, input int ba, input int bb,
                          input int fp, input bit rdy, input bit hold = 0);
    sample_t s;
    s.pa = 10'(pa); s.pb = 10'(pb); s.ba = 10'(ba); s.bb = 10'(bb);
    s.fp = 16'(fp); s.rdy = rdy; s.hold = hold;
    pending_q.push_back(s);
  endtask

  task automatic write_reg(input dppt_pkg::reg_idx_t idx, input int val);
    @(posedge clk);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= 16'(val);
    case (idx)
      dppt_pkg::REG_PEDAL_A_LOW:      cal.pedal_a_low      = 10'(val);
      dppt_pkg::REG_PEDAL_A_HIGH:     cal.pedal_a_high     = 10'(val);
      dppt_pkg::REG_PEDAL_B_LOW:      cal.pedal_b_low      = 10'(val);
      dppt_pkg::REG_PEDAL_B_HIGH:     cal.pedal_b_high     = 10'(val);
      dppt_pkg::REG_TORQUE_LIMIT:     cal.torque_limit     = 12'(val);
      dppt_pkg::REG_COAST_REGEN:      cal.coast_regen      = 12'(val);
      dppt_pkg::REG_BRAKE_REGEN_GAIN: cal.brake_regen_gain = 16'(val);
      default:                        cal.brake_full_scale = 16'(val);
    endcase
    @(posedge clk);
    wr_en <= 1'b0;
  endtask

  task automatic drain;
    while (pending_q.size() > 0 || expected_q.size() > 0 || start) @(posedge clk);
    repeat (15) @(posedge clk);
  endtask

  task automatic calibrate(input int al, input int ah, input int bl, input int bh,
                           input int lim, input int coast, input int gain, input int fs);
    write_reg(dppt_pkg::REG_PEDAL_A_LOW, al);
    write_reg(dppt_pkg::REG_PEDAL_A_HIGH, ah);
    write_reg(dppt_pkg::REG_PEDAL_B_LOW, bl);
    write_reg(dppt_pkg::REG_PEDAL_B_HIGH, bh);
    write_reg(dppt_pkg::REG_TORQUE_LIMIT, lim);
    write_reg(dppt_pkg::REG_COAST_REGEN, coast);
    write_reg(dppt_pkg::REG_BRAKE_REGEN_GAIN, gain);
    write_reg(dppt_pkg::REG_BRAKE_FULL_SCALE, fs);
  endtask

  // mostly plausible pedal pairs: pick a shared position, map back to raw
  task automatic random_items(input int n);
    int p, pa, pb, ka, kb;
    for (int i = 0; i < n; i++) begin
      ka = $urandom_range(0, 9);
      if (ka < 7 && cal.pedal_a_high > cal.pedal_a_low && cal.pedal_b_high > cal.pedal_b_low) begin
        p  = $urandom_range(0, 255);
        pa = cal.pedal_a_low + p * (cal.pedal_a_high - cal.pedal_a_low) / 255
             + $urandom_range(0, 3);
        kb = p + $urandom_range(0, 16) - 8;
        if (kb < 0) kb = 0;
        pb = cal.pedal_b_low + kb * (cal.pedal_b_high - cal.pedal_b_low) / 255;
        if ($urandom_range(0, 9) == 0) pa = cal.pedal_a_high + $urandom_range(0, 50);
        if (pa > 1023) pa = 1023;
        if (pb > 1023) pb = 1023;
      end else begin
        pa = $urandom_range(0, 1023);
        pb = $urandom_range(0, 1023);
      end
      add_item(pa, pb, $urandom_range(0, 1023), $urandom_range(0, 1023),
               ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 65535),
               $urandom_range(0, 7) != 0);
    end
  endtask

  initial begin
    cal = '{pedal_a_low: 189, pedal_a_high: 849, pedal_b_low: 91, pedal_b_high: 417,
            torque_limit: 50, coast_regen: 10, brake_regen_gain: 0,
            brake_full_scale: 3000};
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed, reset calibration
    add_item(189, 91, 0, 1023, 0, 1);        // both at rest
    add_item(849, 417, 1023, 0, 65535, 1);   // both full
    add_item(889, 417, 512, 512, 1, 1);      // a at high plus margin, saturates
    add_item(890, 417, 1, 2, 2, 1);          // a just over margin
    add_item(188, 91, 3, 4, 3, 1);           // a under travel
    add_item(849, 91, 5, 6, 4, 1);           // mismatch
    add_item(519, 254, 7, 8, 5, 0);          // mid, not ready
    add_item(1023, 1023, 1023, 1023, 65535, 1);
    add_item(0, 0, 0, 0, 0, 0);
    add_item(519, 254, 341, 682, 43690, 1, 1); // after drain
    random_items(60);
    drain();

    // extreme calibration: big limits, max regen gain, degenerate b band
    calibrate(0, 1023, 1023, 1023, 3276, 3276, 65535, 65535);
    add_item(0, 0, 1023, 1023, 65535, 1);
    add_item(1023, 1023, 0, 0, 0, 1);
    add_item(500, 500, 1, 1, 1, 1);
    drain();
    calibrate(0, 1023, 0, 1023, 3276, 3276, 65535, 65535);
    add_item(1023, 1023, 1023, 1023, 65535, 1);
    add_item(0, 0, 1023, 0, 65535, 1);
    add_item(0, 0, 1023, 0, 0, 1);
    random_items(150);
    drain();

    calibrate(10, 20, 1000, 1010, 0, 0, 0, 0);
    add_item(20, 1010, 1023, 1023, 65535, 1);
    add_item(60, 1023, 1023, 1023, 65535, 1);
    random_items(120);
    drain();

    calibrate(100, 900, 50, 450, 1200, 25, 3, 2000);
    random_items(150);
    drain();

    calibrate(200, 800, 150, 600, 400, 40, 100, 4096);
    sender_calm = 1;
    random_items(150);
    drain();

    $display("covered %0d sample sets (%0d results) over six calibrations: %0d faulted, %0d regen",
             n_items, n_results, n_faults, n_regen);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d mismatches, %0d results outstanding", mismatches, expected_q.size());
      $display("simulation failed");
    end
    $finish;
  end

endmodule
